// ===== hw/rtl/fgn_pkg.sv =====
`default_nettype none

package fgn_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRE,
    S_XY,
    S_MOD,
    S_OCT,
    S_DIV0,
    S_DIV,
    S_DONE
  } fgn_state_t;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  localparam logic [1:0] REG_OCTAVE_COUNT  = 2'd0;
  localparam logic [1:0] REG_PERSISTENCE   = 2'd1;
  localparam logic [1:0] REG_INV_BASE_FREQ = 2'd2;

  localparam logic [3:0]  OCTAVE_COUNT_RST  = 4'd4;
  localparam logic [15:0] PERSISTENCE_RST   = 16'd32768;
  localparam logic [23:0] INV_BASE_FREQ_RST = 24'd65536;

  localparam logic [16:0] AMP_ONE  = 17'd65536;
  localparam logic [15:0] Q_SAT    = 16'hFFFF;
  localparam logic [4:0]  PRE_LAST = 5'd2;
  localparam logic [4:0]  OCT_LAST = 5'd21;
  localparam logic [4:0]  DIV_LAST = 5'd15;

  // u = 6*t*t/2^16 + 10 - 15*t, Q.16, from the registered square t*t
  function automatic logic [23:0] fade_u(input logic [31:0] sq, input logic [15:0] t);
    logic [34:0] sq6;
    logic [19:0] t15;
    sq6 = ({3'b0, sq} << 2) + ({3'b0, sq} << 1);
    t15 = ({4'b0, t} << 4) - {4'b0, t};
    fade_u = {5'b0, sq6[34:16]} + 24'd655360 - {4'b0, t15};
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fgn_ram.sv =====
`default_nettype none

module fgn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fractal_gradient_noise_2d_unit.sv =====
// Fractal 2-D gradient noise. A load item (func 0) writes one gradient into the
// GRID_SIDE x GRID_SIDE row-major table and the block stays ready; reading an
// entry never loaded gives an undefined result. An evaluate item (func 1) runs
// N octaves, N the clamped octave count, and reduces the cell-index remainder
// eight index bits at a time; the division is skipped when the result is zero
// or saturates. All products go one per cycle through a single registered
// 25x25 multiplier, and the four corner gradients come from the one read port
// of the table. The block takes no item until its result sits in the output
// register.
`default_nettype none

module fractal_gradient_noise_2d_unit import fgn_pkg::*; #(
  parameter int GRID_SIDE   = 64,
  parameter int MAX_OCTAVES = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_func,
  input  wire logic [11:0]        in_grad_index,
  input  wire logic signed [15:0] in_grad_x,
  input  wire logic signed [15:0] in_grad_y,
  input  wire logic [23:0]        in_coord_x,
  input  wire logic [23:0]        in_coord_y,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [15:0]             out_noise_value,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int TABLE = GRID_SIDE * GRID_SIDE;
  localparam int AW    = $clog2(TABLE);
  localparam int CW    = $clog2(GRID_SIDE);
  localparam int CW1   = CW + 1;
  localparam int PW    = 48 + MAX_OCTAVES - 1;
  localparam int XW    = PW + 1;
  localparam int IXW   = XW - 24;
  localparam int IW    = ((IXW + 7) / 8) * 8;
  localparam int NMOD  = IW / 8;
  localparam int OW    = $clog2(MAX_OCTAVES + 1);
  localparam logic [CW:0]   GSIDE    = CW1'(GRID_SIDE);
  localparam logic [CW-1:0] CELL_TOP = CW'(GRID_SIDE - 1);
  localparam logic [4:0]    MOD_LAST = 5'(NMOD - 1);

  fgn_state_t state_r, state_nxt;
  logic [4:0]    step_r;
  logic [OW-1:0] oct_r;
  logic          out_valid_r;
  logic [15:0]   out_noise_value_r;

  logic [3:0]  oct_cnt_r;
  logic [15:0] pers_r;
  logic [23:0] inv_r;

  logic [23:0]        cx_r, cy_r;
  logic [PW-1:0]      pxs_r, pys_r;
  logic [IW-1:0]      ix_r, iy_r;
  logic [CW-1:0]      x0_r, y0_r;
  logic [15:0]        tx_r, ty_r;
  logic signed [49:0] prod_r;
  logic [23:0]        u_r;
  logic [16:0]        fx_r, fy_r;
  logic [31:0]        g_r [4];
  logic [33:0]        acc_r;
  logic [19:0]        n_r [4];
  logic [19:0]        r0_r, r1_r, val_r;
  logic [16:0]        amp_r;
  logic [20:0]        wt_r;
  logic [43:0]        sum_r;
  logic [37:0]        rem_r;
  logic [36:0]        dsh_r;
  logic [15:0]        q_r;

  logic signed [24:0] mul_a, mul_b;
  logic [AW-1:0]      ram_raddr;
  logic [31:0]        ram_rdata;
  logic               ram_we;
  logic               in_acc, eval_acc, cfg_wr;
  logic [OW-1:0]      n_oct;
  logic [XW-1:0]      xfull, yfull;
  logic [CW:0]        mx, my;
  logic [CW-1:0]      x1, y1;
  logic [34:0]        csum;
  logic [43:0]        div_num;
  logic               div_zero, div_sat, div_ge;

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] cx, input logic [CW-1:0] cy);
    cell_addr = AW'(int'(cy) * GRID_SIDE + int'(cx));
  endfunction

  function automatic logic signed [24:0] s17(input logic [16:0] v);
    s17 = {{8{v[16]}}, v};
  endfunction

  function automatic logic signed [24:0] s16(input logic [15:0] v);
    s16 = {{9{v[15]}}, v};
  endfunction

  function automatic logic signed [24:0] s21(input logic [20:0] v);
    s21 = {{4{v[20]}}, v};
  endfunction

  function automatic logic signed [24:0] u17(input logic [16:0] v);
    u17 = {8'b0, v};
  endfunction

  function automatic logic [20:0] dif(input logic [19:0] b, input logic [19:0] a);
    dif = {b[19], b} - {a[19], a};
  endfunction

  assign in_acc   = in_valid && in_ready;
  assign eval_acc = in_acc && (in_func == FUNC_EVAL);
  assign ram_we   = in_acc && (in_func == FUNC_LOAD) && (int'(in_grad_index) < TABLE);
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_noise_value = out_noise_value_r;

  always_comb begin
    if (oct_cnt_r == 4'd0) begin
      n_oct = OW'(1);
    end else if (int'(oct_cnt_r) > MAX_OCTAVES) begin
      n_oct = OW'(MAX_OCTAVES);
    end else begin
      n_oct = OW'(oct_cnt_r);
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_OCTAVE_COUNT:  prdata = {28'b0, oct_cnt_r};
      REG_PERSISTENCE:   prdata = {16'b0, pers_r};
      REG_INV_BASE_FREQ: prdata = {8'b0, inv_r};
      default:           prdata = 32'b0;
    endcase
  end

  assign xfull = {1'b0, pxs_r} + XW'({inv_r, 7'b0});
  assign yfull = {1'b0, pys_r} + XW'({inv_r, 7'b0});

  always_comb begin
    mx = {1'b0, x0_r};
    my = {1'b0, y0_r};
    for (int k = 7; k >= 0; k--) begin
      mx = {mx[CW-1:0], ix_r[IW-8+k]};
      if (mx >= GSIDE) mx = mx - GSIDE;
      my = {my[CW-1:0], iy_r[IW-8+k]};
      if (my >= GSIDE) my = my - GSIDE;
    end
  end

  assign x1 = (x0_r == CELL_TOP) ? '0 : x0_r + CW'(1);
  assign y1 = (y0_r == CELL_TOP) ? '0 : y0_r + CW'(1);

  assign csum     = {acc_r[33], acc_r} + {prod_r[33], prod_r[33:0]};
  assign div_num  = sum_r + {7'b0, wt_r, 16'b0};
  assign div_zero = div_num[43] || (div_num == 44'b0);
  assign div_sat  = div_num >= {6'b0, wt_r, 17'b0};
  assign div_ge   = rem_r >= {1'b0, dsh_r};

  fgn_ram #(
    .WIDTH(32),
    .DEPTH(TABLE)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(AW'(in_grad_index)),
    .wdata({in_grad_y, in_grad_x}),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (eval_acc) state_nxt = S_PRE;
      S_PRE:  if (step_r == PRE_LAST) state_nxt = S_XY;
      S_XY:   state_nxt = S_MOD;
      S_MOD:  if (step_r == MOD_LAST) state_nxt = S_OCT;
      S_OCT: begin
        if (step_r == OCT_LAST) state_nxt = (oct_r == OW'(1)) ? S_DIV0 : S_XY;
      end
      S_DIV0: state_nxt = (div_zero || div_sat) ? S_DONE : S_DIV;
      S_DIV:  if (step_r == DIV_LAST) state_nxt = S_DONE;
      S_DONE: if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == S_IDLE);
    mul_a     = '0;
    mul_b     = '0;
    ram_raddr = cell_addr(x0_r, y0_r);
    case (state_r)
      S_PRE: begin
        mul_a = {1'b0, inv_r};
        mul_b = (step_r == 5'd0) ? {1'b0, cx_r} : {1'b0, cy_r};
      end
      S_OCT: begin
        case (step_r)
          5'd0: begin
            mul_a = u17({1'b0, tx_r}); mul_b = u17({1'b0, tx_r});
          end
          5'd1: begin
            mul_a = u17({1'b0, prod_r[31:16]}); mul_b = u17({1'b0, tx_r});
            ram_raddr = cell_addr(x1, y0_r);
          end
          5'd2: begin
            mul_a = u17({1'b0, prod_r[31:16]}); mul_b = {1'b0, u_r};
            ram_raddr = cell_addr(x0_r, y1);
          end
          5'd3: begin
            mul_a = u17({1'b0, ty_r}); mul_b = u17({1'b0, ty_r});
            ram_raddr = cell_addr(x1, y1);
          end
          5'd4: begin
            mul_a = u17({1'b0, prod_r[31:16]}); mul_b = u17({1'b0, ty_r});
          end
          5'd5: begin
            mul_a = u17({1'b0, prod_r[31:16]}); mul_b = {1'b0, u_r};
          end
          5'd6:  begin mul_a = s17({1'b0, tx_r}); mul_b = s16(g_r[0][15:0]);  end
          5'd7:  begin mul_a = s17({1'b0, ty_r}); mul_b = s16(g_r[0][31:16]); end
          5'd8:  begin mul_a = s17({1'b1, tx_r}); mul_b = s16(g_r[1][15:0]);  end
          5'd9:  begin mul_a = s17({1'b0, ty_r}); mul_b = s16(g_r[1][31:16]); end
          5'd10: begin mul_a = s17({1'b0, tx_r}); mul_b = s16(g_r[2][15:0]);  end
          5'd11: begin mul_a = s17({1'b1, ty_r}); mul_b = s16(g_r[2][31:16]); end
          5'd12: begin mul_a = s17({1'b1, tx_r}); mul_b = s16(g_r[3][15:0]);  end
          5'd13: begin mul_a = s17({1'b1, ty_r}); mul_b = s16(g_r[3][31:16]); end
          5'd14: begin mul_a = s21(dif(n_r[1], n_r[0])); mul_b = u17(fx_r); end
          5'd15: begin mul_a = s21(dif(n_r[3], n_r[2])); mul_b = u17(fx_r); end
          5'd17: begin mul_a = s21(dif(r1_r, r0_r));     mul_b = u17(fy_r); end
          5'd19: begin mul_a = u17(amp_r); mul_b = {{5{val_r[19]}}, val_r}; end
          5'd20: begin mul_a = u17(amp_r); mul_b = u17({1'b0, pers_r}); end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      oct_r       <= '0;
      out_valid_r <= 1'b0;
      oct_cnt_r   <= OCTAVE_COUNT_RST;
      pers_r      <= PERSISTENCE_RST;
      inv_r       <= INV_BASE_FREQ_RST;
    end else begin
      state_r <= state_nxt;
      step_r  <= (state_nxt != state_r) ? 5'd0 : step_r + 5'd1;
      if (eval_acc) begin
        oct_r <= n_oct;
      end else if (state_r == S_OCT && step_r == OCT_LAST) begin
        oct_r <= oct_r - OW'(1);
      end
      if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_OCTAVE_COUNT:  oct_cnt_r <= pwdata[3:0];
          REG_PERSISTENCE:   pers_r    <= pwdata[15:0];
          REG_INV_BASE_FREQ: inv_r     <= pwdata[23:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_noise_value_r <= q_r;
    end
    case (state_r)
      S_IDLE: begin
        cx_r  <= in_coord_x;
        cy_r  <= in_coord_y;
        amp_r <= AMP_ONE;
        wt_r  <= '0;
        sum_r <= '0;
      end
      S_PRE: begin
        if (step_r == 5'd1) pxs_r <= PW'(prod_r[47:0]);
        if (step_r == 5'd2) pys_r <= PW'(prod_r[47:0]);
      end
      S_XY: begin
        ix_r <= IW'(xfull[XW-1:24]);
        iy_r <= IW'(yfull[XW-1:24]);
        tx_r <= xfull[23:8];
        ty_r <= yfull[23:8];
        x0_r <= '0;
        y0_r <= '0;
      end
      S_MOD: begin
        x0_r <= mx[CW-1:0];
        y0_r <= my[CW-1:0];
        ix_r <= ix_r << 8;
        iy_r <= iy_r << 8;
      end
      S_OCT: begin
        case (step_r)
          5'd1:  begin u_r <= fade_u(prod_r[31:0], tx_r); g_r[0] <= ram_rdata; end
          5'd2:  g_r[1] <= ram_rdata;
          5'd3:  begin fx_r <= prod_r[32:16]; g_r[2] <= ram_rdata; end
          5'd4:  begin u_r <= fade_u(prod_r[31:0], ty_r); g_r[3] <= ram_rdata; end
          5'd6:  fy_r <= prod_r[32:16];
          5'd7, 5'd9, 5'd11, 5'd13: acc_r <= prod_r[33:0];
          5'd8:  n_r[0] <= csum[34:15];
          5'd10: n_r[1] <= csum[34:15];
          5'd12: n_r[2] <= csum[34:15];
          5'd14: n_r[3] <= csum[34:15];
          5'd15: r0_r <= n_r[0] + prod_r[35:16];
          5'd16: r1_r <= n_r[2] + prod_r[35:16];
          5'd18: val_r <= r0_r + prod_r[35:16];
          5'd20: sum_r <= sum_r + {{6{prod_r[37]}}, prod_r[37:0]};
          5'd21: begin
            wt_r  <= wt_r + {4'b0, amp_r};
            amp_r <= prod_r[32:16];
            pxs_r <= {pxs_r[PW-2:0], 1'b0};
            pys_r <= {pys_r[PW-2:0], 1'b0};
          end
          default: ;
        endcase
      end
      S_DIV0: begin
        rem_r <= div_num[37:0];
        dsh_r <= {wt_r, 1'b0, 15'b0};
        q_r   <= div_zero ? 16'b0 : (div_sat ? Q_SAT : 16'b0);
      end
      S_DIV: begin
        if (div_ge) rem_r <= rem_r - {1'b0, dsh_r};
        q_r   <= {q_r[14:0], div_ge};
        dsh_r <= dsh_r >> 1;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fgn_checker.sv =====
`default_nettype none

module fgn_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_func,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_noise_value,
  input wire logic        pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_noise_value))
    else $error("result item dropped or changed while stalled");

  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_func |=> !in_ready)
    else $error("ready after an evaluate item");

  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_func |=> in_ready)
    else $error("not ready after a load item");

  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result item without an evaluate in flight");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind fractal_gradient_noise_2d_unit fgn_checker u_fgn_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_func        (in_func),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_noise_value(out_noise_value),
  .pready         (pready)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fgn_pkg::*;

  localparam int SIDE = 64;
  localparam int ENTRIES = SIDE * SIDE;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE = 300;

  class noise_scoreboard;
    logic [31:0] grads[ENTRIES];
    logic [3:0]  octaves;
    logic [15:0] persist;
    logic [23:0] inv_freq;
    logic [15:0] noise_q[$];

    function new();
      octaves = OCTAVE_COUNT_RST;
      persist = PERSISTENCE_RST;
      inv_freq = INV_BASE_FREQ_RST;
    endfunction

    function longint fade(longint t);
      longint u;
      longint t3;
      u = ((6 * t * t) >>> 16) + 655360 - 15 * t;
      t3 = (((t * t) >>> 16) * t) >>> 16;
      return (t3 * u) >>> 16;
    endfunction

    function longint corner(longint cx, longint cy, longint dx, longint dy);
      logic [31:0] e;
      longint gx;
      longint gy;
      e = grads[cy * SIDE + cx];
      gx = longint'($signed(e[15:0]));
      gy = longint'($signed(e[31:16]));
      return (dx * gx + dy * gy) >>> 15;
    endfunction

    function longint blend(longint a, longint b, longint f);
      return a + (((b - a) * f) >>> 16);
    endfunction

    function longint octave_noise(logic [23:0] px, logic [23:0] py, int i);
      longint inv, sx, sy, x0, y0, x1, y1, tx, ty, fx, fy, r0, r1;
      inv = longint'(inv_freq);
      sx = ((longint'(px) << i) * inv) + (inv << 7);
      sy = ((longint'(py) << i) * inv) + (inv << 7);
      x0 = (sx >> 24) % SIDE;
      y0 = (sy >> 24) % SIDE;
      x1 = (x0 + 1) % SIDE;
      y1 = (y0 + 1) % SIDE;
      tx = (sx >> 8) & 65535;
      ty = (sy >> 8) & 65535;
      fx = fade(tx);
      fy = fade(ty);
      r0 = blend(corner(x0, y0, tx, ty), corner(x1, y0, tx - 65536, ty), fx);
      r1 = blend(corner(x0, y1, tx, ty - 65536),
                 corner(x1, y1, tx - 65536, ty - 65536), fx);
      return blend(r0, r1, fy);
    endfunction

    function void note_item(logic fn, logic [11:0] idx, logic [15:0] gx, logic [15:0] gy,
                            logic [23:0] px, logic [23:0] py);
      int n;
      longint total, amp, weight, num, q;
      if (fn == FUNC_LOAD) begin
        if (int'(idx) < ENTRIES) grads[idx] = {gy, gx};
        return;
      end
      n = int'(octaves);
      if (n < 1) n = 1;
      if (n > 8) n = 8;
      total = 0;
      amp = 65536;
      weight = 0;
      for (int i = 0; i < n; i++) begin
        total += amp * octave_noise(px, py, i);
        weight += amp;
        amp = (amp * longint'(persist)) >> 16;
      end
      num = total + weight * 65536;
      if (num <= 0) q = 0;
      else begin
        q = num / (2 * weight);
        if (q > 65535) q = 65535;
      end
      noise_q.push_back(q[15:0]);
    endfunction

    function bit check_noise(logic [15:0] got, output logic [15:0] want, output bit none);
      none = (noise_q.size() == 0);
      want = '0;
      if (none) return 0;
      want = noise_q.pop_front();
      return got === want;
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_func;
  logic [11:0] in_grad_index;
  logic [15:0] in_grad_x;
  logic [15:0] in_grad_y;
  logic [23:0] in_coord_x;
  logic [23:0] in_coord_y;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_noise_value;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  noise_scoreboard sb;
  int  errors;
  int  cycles;
  int  evals_sent;
  int  loads_sent;
  int  results_seen;
  bit  calm;

  fractal_gradient_noise_2d_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func),
    .in_grad_index(in_grad_index), .in_grad_x(in_grad_x), .in_grad_y(in_grad_y),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y),
    .out_valid(out_valid), .out_ready(out_ready), .out_noise_value(out_noise_value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task report(input string what, input logic [15:0] got, input logic [15:0] want);
    errors++;
    $display("mismatch at cycle %0d: %s got %0d want %0d", cycles, what, got, want);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_top: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    logic [15:0] want;
    bit none;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (!sb.check_noise(out_noise_value, want, none)) begin
        if (none) report("unexpected noise_value", out_noise_value, '0);
        else report("noise_value", out_noise_value, want);
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 10);
    end
  end

  task send_item(input logic fn, input logic [11:0] idx, input logic [15:0] gx,
                 input logic [15:0] gy, input logic [23:0] px, input logic [23:0] py);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= fn;
    in_grad_index <= idx;
    in_grad_x <= gx;
    in_grad_y <= gy;
    in_coord_x <= px;
    in_coord_y <= py;
    do @(posedge clk); while (!in_ready);
    sb.note_item(fn, idx, gx, gy, px, py);
    if (fn == FUNC_EVAL) evals_sent++;
    else loads_sent++;
  endtask

  task drop_valid();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task drain();
    drop_valid();
    while (sb.noise_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task cfg_write(input logic [1:0] r, input logic [31:0] d);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= d;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (r)
      REG_OCTAVE_COUNT:  sb.octaves = d[3:0];
      REG_PERSISTENCE:   sb.persist = d[15:0];
      REG_INV_BASE_FREQ: sb.inv_freq = d[23:0];
      default: ;
    endcase
  endtask

  task set_config(input logic [3:0] oc, input logic [15:0] pe, input logic [23:0] ib);
    cfg_write(REG_OCTAVE_COUNT, {28'd0, oc});
    cfg_write(REG_PERSISTENCE, {16'd0, pe});
    cfg_write(REG_INV_BASE_FREQ, {8'd0, ib});
  endtask

  task random_eval();
    logic [23:0] px, py;
    case ($urandom_range(3))
      0: begin px = 24'($urandom); py = 24'($urandom); end
      1: begin px = 24'($urandom_range(4095)); py = 24'($urandom_range(4095)); end
      2: begin px = 24'($urandom_range(255)); py = 24'($urandom); end
      default: begin
        px = 24'hFFFFFF - 24'($urandom_range(255));
        py = 24'($urandom_range(65535));
      end
    endcase
    send_item(FUNC_EVAL, 12'($urandom), 16'($urandom), 16'($urandom), px, py);
  endtask

  task random_phase(input int count);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 70) random_eval();
      else send_item(FUNC_LOAD, 12'($urandom), 16'($urandom), 16'($urandom),
                     24'($urandom), 24'($urandom));
    end
  endtask

  initial begin
    sb = new();
    errors = 0;
    evals_sent = 0;
    loads_sent = 0;
    calm = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = FUNC_LOAD;
    in_grad_index = '0;
    in_grad_x = '0;
    in_grad_y = '0;
    in_coord_x = '0;
    in_coord_y = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // fill the table so that no evaluate reads an unloaded entry
    for (int e = 0; e < ENTRIES; e++) begin
      case (e % 4)
        0: send_item(FUNC_LOAD, 12'(e), 16'h7FFF, 16'h8000, '0, '0);
        1: send_item(FUNC_LOAD, 12'(e), 16'h8000, 16'h7FFF, '0, '0);
        default: send_item(FUNC_LOAD, 12'(e), 16'($urandom), 16'($urandom),
                           24'($urandom), 24'($urandom));
      endcase
    end

    send_item(FUNC_EVAL, '0, '0, '0, 24'h000000, 24'h000000);
    send_item(FUNC_EVAL, '0, '0, '0, 24'hFFFFFF, 24'hFFFFFF);
    send_item(FUNC_EVAL, '0, '0, '0, 24'hFFFFFF, 24'h000000);
    send_item(FUNC_EVAL, '0, '0, '0, 24'h000000, 24'hFFFFFF);
    send_item(FUNC_EVAL, '0, '0, '0, 24'h000080, 24'h0000FF);
    send_item(FUNC_LOAD, 12'd0, 16'h7FFF, 16'h7FFF, '0, '0);
    send_item(FUNC_LOAD, 12'd4095, 16'h8000, 16'h8000, '0, '0);
    send_item(FUNC_EVAL, '0, '0, '0, 24'h003F80, 24'h003F80);
    send_item(FUNC_EVAL, '0, '0, '0, 24'h000040, 24'h000040);
    drain();

    set_config(4'd0, 16'd12345, 24'd0);
    send_item(FUNC_EVAL, '0, '0, '0, 24'h123456, 24'hABCDEF);
    send_item(FUNC_EVAL, '0, '0, '0, 24'hFFFFFF, 24'h000000);
    drain();
    set_config(4'd15, 16'd65535, 24'hFFFFFF);
    send_item(FUNC_EVAL, '0, '0, '0, 24'hFFFFFF, 24'hFFFFFF);
    send_item(FUNC_EVAL, '0, '0, '0, 24'h000001, 24'h000001);
    drain();

    set_config(4'd1, 16'd0, 24'd1);
    random_phase(100);
    drain();
    set_config(4'd8, 16'd65535, 24'hFFFFFF);
    random_phase(100);
    drain();
    set_config(4'd4, 16'd32768, 24'd65536);
    calm = 1'b1;
    random_phase(100);
    calm = 1'b0;
    drain();
    set_config(4'd0, 16'd0, 24'd0);
    random_phase(60);
    drain();
    set_config(4'($urandom_range(8, 1)), 16'($urandom), 24'($urandom_range(24'h1FFFF, 1)));
    random_phase(120);
    drain();
    set_config(4'd2, 16'($urandom), 24'($urandom));
    random_phase(120);
    drain();

    if (sb.noise_q.size() > 0) report("results never arrived", '0, 16'(sb.noise_q.size()));
    $display("covered %0d loads and %0d evaluates, %0d results checked", loads_sent,
             evals_sent, results_seen);
    $display("octave counts 0..15, persistence and base reciprocal extremes included");
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/fgn_pkg.sv
hw/rtl/fgn_ram.sv
hw/rtl/fractal_gradient_noise_2d_unit.sv
hw/rtl/fgn_checker.sv
tb/tb_top.sv
